@@ design/hbc_pkg.sv @@
package hbc_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BINS_DEF     = 64;
  localparam int COUNTER_BITS_DEF = 48;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [31:0] RANGE_HIGH_RST = 32'd64;
  localparam logic [6:0]  BINS_RST       = 7'd64;
  localparam logic [15:0] LOG_BASE_RST   = 16'd512;

  // Log edges never grow past this value, above any sample
  localparam logic [42:0] EDGE_CAP = 43'h001_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_KIND   = 3'd0,
    CFG_RANGE_LOW  = 3'd1,
    CFG_RANGE_HIGH = 3'd2,
    CFG_BINS       = 3'd3,
    CFG_LOG_BASE   = 3'd4
  } hbc_cfg_idx_e;

  typedef enum logic {
    KIND_LINEAR = 1'b0,
    KIND_LOG    = 1'b1
  } hbc_kind_e;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } hbc_mode_e;

  typedef enum logic [1:0] {
    RGN_BELOW  = 2'd0,
    RGN_INSIDE = 2'd1,
    RGN_ABOVE  = 2'd2,
    RGN_NONE   = 2'd3
  } hbc_region_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CLASSIFY,
    ST_LIN_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_LOG_MUL,
    ST_LOG_CMP,
    ST_SUM_MUL,
    ST_COMMIT,
    ST_READ,
    ST_READ_DATA,
    ST_DONE
  } hbc_state_e;

endpackage

@@ design/hbc_mul.sv @@
module hbc_mul (
  input  logic                                 clk_i,
  input  logic signed [hbc_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [hbc_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [hbc_pkg::MUL_P_W-1:0]   p_o
);
  import hbc_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // Register the product before anyone uses it
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ design/hbc_div.sv @@
module hbc_div #(
  parameter int QW = 6,
  parameter int DW = 39
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);
  import hbc_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [31:0]   rem_q, rem_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW-1:0] hi_part;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // One restoring step: bring down the next dividend bit, try a subtract
  always_comb begin
    hi_part = dividend_i >> QW;
    trial   = {rem_q, quot_q[QW-1]};
    diff    = trial - {1'b0, divisor_i};
    ge      = trial >= {1'b0, divisor_i};
  end

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // Upper part is known to stay under the divisor
      rem_d  = hi_part[31:0];
      quot_d = dividend_i[QW-1:0];
      cnt_d  = CW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[31:0] : trial[31:0];
      quot_d = QW'({quot_q, ge});
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/hbc_bin_ram.sv @@
module hbc_bin_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  import hbc_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/histogram_binning_counter_core.sv @@
// Histogram core with linear or logarithmic binning and saturating counters.
// Input channel (in_valid_i / in_stall_o) carries one item: an add, a clear
// or a read. Output channel (out_valid_o / out_stall_i) returns exactly one
// result per item: region, bin hit, selected counter, running total and sum.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must do so only while the block is idle, which the block does not enforce;
// the registers take effect for the next item. One item is worked on at a
// time; in_stall_o stays high until its result has been loaded into the output
// register. Work per item, from accept:
//   add, below or above range ......... classify, then the sum multiply
//   add, linear inside ................ runs the bit-serial divider
//   add, log mode ..................... one pass of the shared multiplier
//                                        per bin edge visited
//   read .............................. one bin memory read
//   clear ............................. memory sweep
// After reset the bin memory is swept to zero before the first item is taken.
// A result that waits on out_stall_i holds in the output register; the next
// item is still accepted, but its result waits until the output register is
// free.
module histogram_binning_counter_core #(
  parameter int NUM_BINS     = hbc_pkg::NUM_BINS_DEF,
  parameter int COUNTER_BITS = hbc_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       mode_i,
  input  logic signed [31:0]               sample_value_i,
  input  logic [15:0]                      repeat_count_i,
  input  logic [6:0]                       counter_select_i,
  // Result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       region_o,
  output logic [5:0]                       bin_hit_o,
  output logic [47:0]                      selected_count_o,
  output logic [47:0]                      total_count_o,
  output logic signed [63:0]               sample_sum_o
);
  import hbc_pkg::*;

  localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NB_W   = $clog2(NUM_BINS + 1);
  localparam int NUM_W  = 32 + NB_W;
  localparam int CNT_W1 = COUNTER_BITS + 1;

  function automatic logic [COUNTER_BITS-1:0] sat_add(
    input logic [COUNTER_BITS-1:0] a,
    input logic [15:0]             b
  );
    logic [COUNTER_BITS:0] s;
    s = {1'b0, a} + CNT_W1'(b);
    sat_add = s[COUNTER_BITS] ? '1 : s[COUNTER_BITS-1:0];
  endfunction

  hbc_state_e state_q, state_d;

  // Configuration registers
  logic        bin_kind_q;
  logic [31:0] range_low_q;
  logic [31:0] range_high_q;
  logic [6:0]  bins_q;
  logic [15:0] log_base_q;

  // Item registers
  logic [31:0]       v_q;
  logic [15:0]       cnt_q;
  logic [6:0]        sel_q;
  logic [NB_W-1:0]   nb_q;
  hbc_region_e       region_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  k_q;
  logic [32:0]       edge_q;
  logic [COUNTER_BITS-1:0] sel_val_q;

  // Counters
  logic [COUNTER_BITS-1:0] below_q;
  logic [COUNTER_BITS-1:0] above_q;
  logic [COUNTER_BITS-1:0] all_q;
  logic [63:0]             sum_q;
  logic [IDX_W-1:0]        clr_addr_q;
  logic                    sweep_item_q;

  // Output register
  logic        out_valid_q;
  hbc_region_e out_region_q;
  logic [5:0]  out_hit_q;
  logic [47:0] out_sel_q;
  logic [47:0] out_total_q;
  logic [63:0] out_sum_q;

  // Control from the sequencer
  logic                    accept;
  logic                    out_load;
  logic                    div_start;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [COUNTER_BITS-1:0] ram_wdata;

  // Datapath results
  logic signed [MUL_P_W-1:0] prod;
  logic [MUL_P_W-1:0]        prod_u;
  logic                      div_done;
  logic [IDX_W-1:0]          div_quot;
  logic [COUNTER_BITS-1:0]   ram_rdata;
  logic [31:0]               nb_full;
  logic [32:0]               diff;
  logic [32:0]               span;
  logic                      span_pos;
  logic                      d_ge_span;
  logic                      v_nonpos;
  logic                      low_nonpos;
  logic                      cls_below;
  logic                      cls_above;
  logic [42:0]               next_raw;
  logic [32:0]               edge_next;
  logic                      v_lt_edge;
  logic                      k_last;
  logic                      sweep_last;
  logic [31:0]               sel_m1;
  logic [31:0]               idx32;
  logic [63:0]               sel_ext;
  logic [63:0]               all_ext;
  logic [63:0]               prod_ext;
  logic                      out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_kind_q   <= KIND_LINEAR;
      range_low_q  <= '0;
      range_high_q <= RANGE_HIGH_RST;
      bins_q       <= BINS_RST;
      log_base_q   <= LOG_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIN_KIND:   bin_kind_q   <= cfg_data_i[0];
        CFG_RANGE_LOW:  range_low_q  <= cfg_data_i;
        CFG_RANGE_HIGH: range_high_q <= cfg_data_i;
        CFG_BINS:       bins_q       <= cfg_data_i[6:0];
        CFG_LOG_BASE:   log_base_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Classification terms
  always_comb begin
    nb_full = (bins_q == 7'd0) ? 32'd1 :
              (32'(bins_q) > NUM_BINS) ? 32'(NUM_BINS) : 32'(bins_q);
    diff       = {v_q[31], v_q} - {range_low_q[31], range_low_q};
    span       = {range_high_q[31], range_high_q} - {range_low_q[31], range_low_q};
    span_pos   = !span[32] && (span != 33'd0);
    d_ge_span  = diff[31:0] >= span[31:0];
    v_nonpos   = v_q[31] || (v_q == 32'd0);
    low_nonpos = range_low_q[31] || (range_low_q == 32'd0);
    cls_below  = diff[32] || ((bin_kind_q == KIND_LOG) && (v_nonpos || low_nonpos));
    cls_above  = !cls_below && (bin_kind_q == KIND_LINEAR) && (!span_pos || d_ge_span);
  end

  // Log edge step from the registered product
  always_comb begin
    prod_u    = prod;
    next_raw  = prod_u[50:8];
    edge_next = (next_raw > EDGE_CAP) ? EDGE_CAP[32:0] : next_raw[32:0];
    v_lt_edge = {11'd0, v_q} < {10'd0, edge_next};
    k_last    = 32'(k_q) == (32'(nb_q) - 32'd1);
  end

  always_comb begin
    sweep_last = 32'(clr_addr_q) == (NUM_BINS - 1);
    sel_m1     = 32'(sel_q) - 32'd1;
    idx32      = 32'(idx_q);
    sel_ext    = 64'(sel_val_q);
    all_ext    = 64'(all_q);
    prod_ext   = {{(64 - MUL_P_W){prod_u[MUL_P_W-1]}}, prod_u};
    out_free   = !out_valid_q || !out_stall_i;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = sweep_item_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_ADD:   state_d = ST_CLASSIFY;
            MODE_CLEAR: state_d = ST_SWEEP;
            MODE_READ:  state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_CLASSIFY: begin
        priority if (cls_below || cls_above) begin
          state_d = ST_SUM_MUL;
        end else if (bin_kind_q == KIND_LOG) begin
          state_d = ST_LOG_MUL;
        end else begin
          state_d = ST_LIN_MUL;
        end
      end
      ST_LIN_MUL:   state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_SUM_MUL;
        end
      end
      ST_LOG_MUL:   state_d = ST_LOG_CMP;
      ST_LOG_CMP: begin
        state_d = (v_lt_edge || k_last) ? ST_SUM_MUL : ST_LOG_MUL;
      end
      ST_SUM_MUL:   state_d = ST_COMMIT;
      ST_COMMIT:    state_d = ST_DONE;
      ST_READ:      state_d = ST_READ_DATA;
      ST_READ_DATA: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept    = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = sat_add(ram_rdata, cnt_q);
    // Sample times count by default
    mul_a     = {{2{v_q[31]}}, v_q};
    mul_b     = {1'b0, cnt_q};
    unique case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: accept = in_valid_i;
      ST_LIN_MUL: begin
        mul_a = {1'b0, diff};
        mul_b = MUL_B_W'(nb_q);
      end
      ST_DIV_START: div_start = 1'b1;
      ST_LOG_MUL: begin
        mul_a = {1'b0, edge_q};
        mul_b = {1'b0, log_base_q};
      end
      ST_SUM_MUL: ram_re = 1'b1;
      ST_COMMIT:  ram_we = (region_q == RGN_INSIDE);
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = sel_m1[IDX_W-1:0];
      end
      ST_DONE:    out_load = out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      clr_addr_q   <= '0;
      sweep_item_q <= 1'b0;
      below_q      <= '0;
      above_q      <= '0;
      all_q        <= '0;
      sum_q        <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        clr_addr_q   <= '0;
        sweep_item_q <= 1'b1;
      end
      if (state_q == ST_SWEEP) begin
        // Zero all counters while the memory is swept
        clr_addr_q <= clr_addr_q + IDX_W'(1);
        below_q    <= '0;
        above_q    <= '0;
        all_q      <= '0;
        sum_q      <= '0;
      end
      if (state_q == ST_COMMIT) begin
        all_q <= sat_add(all_q, cnt_q);
        sum_q <= sum_q + prod_ext;
        if (region_q == RGN_BELOW) begin
          below_q <= sat_add(below_q, cnt_q);
        end
        if (region_q == RGN_ABOVE) begin
          above_q <= sat_add(above_q, cnt_q);
        end
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q       <= sample_value_i;
      cnt_q     <= repeat_count_i;
      sel_q     <= counter_select_i;
      nb_q      <= nb_full[NB_W-1:0];
      region_q  <= RGN_NONE;
      idx_q     <= '0;
      sel_val_q <= '0;
    end
    unique case (state_q)
      ST_CLASSIFY: begin
        edge_q <= {1'b0, range_low_q};
        k_q    <= '0;
        if (cls_below) begin
          region_q <= RGN_BELOW;
        end else if (cls_above) begin
          region_q <= RGN_ABOVE;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          idx_q    <= div_quot;
          region_q <= RGN_INSIDE;
        end
      end
      ST_LOG_CMP: begin
        priority if (v_lt_edge) begin
          idx_q    <= k_q;
          region_q <= RGN_INSIDE;
        end else if (k_last) begin
          region_q <= RGN_ABOVE;
        end else begin
          edge_q <= edge_next;
          k_q    <= k_q + IDX_W'(1);
        end
      end
      ST_READ_DATA: begin
        priority if (sel_q == 7'd0) begin
          sel_val_q <= below_q;
        end else if (32'(sel_q) <= NUM_BINS) begin
          sel_val_q <= ram_rdata;
        end else if (32'(sel_q) == NUM_BINS + 1) begin
          sel_val_q <= above_q;
        end else begin
          sel_val_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_region_q <= region_q;
      out_hit_q    <= (region_q == RGN_INSIDE) ? idx32[5:0] : 6'd0;
      out_sel_q    <= sel_ext[47:0];
      out_total_q  <= all_ext[47:0];
      out_sum_q    <= sum_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign region_o         = out_region_q;
  assign bin_hit_o        = out_hit_q;
  assign selected_count_o = out_sel_q;
  assign total_count_o    = out_total_q;
  assign sample_sum_o     = out_sum_q;

  hbc_mul u_mul (
    .clk_i (clk_i),
    .a_i   ($signed(mul_a)),
    .b_i   ($signed(mul_b)),
    .p_o   (prod)
  );

  hbc_div #(
    .QW (IDX_W),
    .DW (NUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_u[NUM_W-1:0]),
    .divisor_i  (span[31:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  hbc_bin_ram #(
    .DEPTH (NUM_BINS),
    .AW    (IDX_W),
    .DW    (COUNTER_BITS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ dv/tb_histogram_binning_counter_core.sv @@
module tb_histogram_binning_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hbc_pkg::*;

  localparam int NUM_BINS = NUM_BINS_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_PAUSE = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_SETTING = 100;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint SAMPLE_MAX = 64'sd2147483647;
  localparam longint SAMPLE_MIN = -64'sd2147483648;
  localparam longint EDGE_LIMIT = longint'(EDGE_CAP);

  typedef struct packed {
    logic [1:0]  region;
    logic [5:0]  bin_hit;
    logic [47:0] sel_cnt;
    logic [47:0] total;
    logic [63:0] sum;
  } hist_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [1:0]   mode;
    logic [31:0]  value;
    logic [15:0]  cnt;
    logic [6:0]   sel;
    logic         typed;
    hbc_region_e  region;
    logic [5:0]   hit;
    logic [47:0]  selcnt;
    hbc_cfg_idx_e reg_idx;
    logic [31:0]  reg_data;
  } stim_row_t;

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            mode_i = '0;
  logic signed [31:0]    sample_value_i = '0;
  logic [15:0]           repeat_count_i = '0;
  logic [6:0]            counter_select_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            region_o;
  logic [5:0]            bin_hit_o;
  logic [47:0]           selected_count_o;
  logic [47:0]           total_count_o;
  logic signed [63:0]    sample_sum_o;

  // Register shadow
  hbc_kind_e          kind_q = KIND_LINEAR;
  logic signed [31:0] low_q = '0;
  logic signed [31:0] high_q = RANGE_HIGH_RST;
  logic [6:0]         bins_q = BINS_RST;
  logic [15:0]        base_q = LOG_BASE_RST;

  // Histogram shadow
  logic [47:0]        hist_bins [NUM_BINS];
  logic [47:0]        under_cnt = '0;
  logic [47:0]        over_cnt = '0;
  logic [47:0]        sample_total = '0;
  logic signed [63:0] weighted_sum = '0;

  hist_result_t pending_results[$];
  hist_result_t want_res;
  stim_row_t    directed_rows[$];

  // Fixed fields for the item on the input port, when known by hand
  logic         typed_q = 1'b0;
  hbc_region_e  typed_region = RGN_NONE;
  logic [5:0]   typed_hit = '0;
  logic [47:0]  typed_selcnt = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  histogram_binning_counter_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .sample_value_i   (sample_value_i),
    .repeat_count_i   (repeat_count_i),
    .counter_select_i (counter_select_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .region_o         (region_o),
    .bin_hit_o        (bin_hit_o),
    .selected_count_o (selected_count_o),
    .total_count_o    (total_count_o),
    .sample_sum_o     (sample_sum_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    foreach (hist_bins[i]) hist_bins[i] = '0;
  end

  function automatic logic [47:0] sat48(logic [47:0] a, logic [15:0] b);
    logic [48:0] s;
    s = a + b;
    return s[48] ? '1 : s[47:0];
  endfunction

  // Work out the result of one item and advance the histogram shadow
  function automatic hist_result_t predict_histogram_result(logic [1:0] mode,
      logic signed [31:0] value, logic [15:0] cnt, logic [6:0] sel);
    hist_result_t res;
    longint v, lo, hi, span, nb, lb, edge_val, nxt, slot;
    bit found;
    res = '0;
    res.region = RGN_NONE;
    v = value;
    lo = low_q;
    hi = high_q;
    lb = base_q;
    nb = (bins_q == 0) ? 1 : (bins_q > NUM_BINS) ? NUM_BINS : bins_q;
    slot = 0;
    if (mode == MODE_ADD) begin
      // classify the sample
      if (v < lo) begin
        res.region = RGN_BELOW;
      end else if (kind_q == KIND_LINEAR) begin
        span = hi - lo;
        if (span <= 0) begin
          res.region = RGN_ABOVE;
        end else begin
          slot = ((v - lo) * nb) / span;
          res.region = (slot >= nb) ? RGN_ABOVE : RGN_INSIDE;
        end
      end else if (v <= 0 || lo <= 0) begin
        res.region = RGN_BELOW;
      end else begin
        // walk the geometric edges, capped above any sample
        edge_val = lo;
        found = 1'b0;
        res.region = RGN_ABOVE;
        for (longint k = 0; k < nb; k++) begin
          nxt = (edge_val * lb) >>> 8;
          if (nxt > EDGE_LIMIT) nxt = EDGE_LIMIT;
          if (!found && v < nxt) begin
            found = 1'b1;
            slot = k;
            res.region = RGN_INSIDE;
          end
          edge_val = nxt;
        end
      end
      case (res.region)
        RGN_BELOW: under_cnt = sat48(under_cnt, cnt);
        RGN_ABOVE: over_cnt = sat48(over_cnt, cnt);
        default: begin
          hist_bins[slot] = sat48(hist_bins[slot], cnt);
          res.bin_hit = slot[5:0];
        end
      endcase
      sample_total = sat48(sample_total, cnt);
      weighted_sum = weighted_sum + v * longint'(cnt);
    end else if (mode == MODE_CLEAR) begin
      foreach (hist_bins[i]) hist_bins[i] = '0;
      under_cnt = '0;
      over_cnt = '0;
      sample_total = '0;
      weighted_sum = '0;
    end else if (mode == MODE_READ) begin
      if (sel == 0) res.sel_cnt = under_cnt;
      else if (sel <= NUM_BINS) res.sel_cnt = hist_bins[sel - 1];
      else if (sel == NUM_BINS + 1) res.sel_cnt = over_cnt;
    end
    res.total = sample_total;
    res.sum = weighted_sum;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, seen, wanted);
    mismatches++;
  endtask

  // Track register writes, check results, predict accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BIN_KIND:   kind_q = hbc_kind_e'(cfg_data_i[0]);
          CFG_RANGE_LOW:  low_q = cfg_data_i;
          CFG_RANGE_HIGH: high_q = cfg_data_i;
          CFG_BINS:       bins_q = cfg_data_i[6:0];
          CFG_LOG_BASE:   base_q = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, total_count", total_count_o, '0);
        end else begin
          want_res = pending_results.pop_front();
          if (region_o !== want_res.region)
            report_mismatch("region", region_o, want_res.region);
          if (bin_hit_o !== want_res.bin_hit)
            report_mismatch("bin_hit", bin_hit_o, want_res.bin_hit);
          if (selected_count_o !== want_res.sel_cnt)
            report_mismatch("selected_count", selected_count_o, want_res.sel_cnt);
          if (total_count_o !== want_res.total)
            report_mismatch("total_count", total_count_o, want_res.total);
          if (sample_sum_o !== want_res.sum)
            report_mismatch("sample_sum", sample_sum_o, want_res.sum);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want_res = predict_histogram_result(mode_i, sample_value_i, repeat_count_i,
                                            counter_select_i);
        if (typed_q) begin
          want_res.region = typed_region;
          want_res.bin_hit = typed_hit;
          want_res.sel_cnt = typed_selcnt;
        end
        pending_results.push_back(want_res);
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  function automatic stim_row_t stim_item(logic [1:0] mode, logic [31:0] value,
      logic [15:0] cnt, logic [6:0] sel, logic typed, hbc_region_e rg,
      logic [5:0] hit, logic [47:0] selcnt);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mode = mode;
    r.value = value;
    r.cnt = cnt;
    r.sel = sel;
    r.typed = typed;
    r.region = rg;
    r.hit = hit;
    r.selcnt = selcnt;
    return r;
  endfunction

  function automatic stim_row_t stim_reg(hbc_cfg_idx_e idx, logic [31:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(logic [1:0] mode, logic [31:0] value, logic [15:0] cnt,
      logic [6:0] sel, logic typed, hbc_region_e rg, logic [5:0] hit,
      logic [47:0] selcnt);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    sample_value_i <= value;
    repeat_count_i <= cnt;
    counter_select_i <= sel;
    typed_q = typed;
    typed_region = rg;
    typed_hit = hit;
    typed_selcnt = selcnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_PAUSE) @(negedge clk_i);
  endtask

  task automatic write_reg(hbc_cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Program one register setting of the given flavor
  task automatic program_setting(int flavor);
    logic [31:0] kind_d, lo_d, hi_d, bins_d, base_d;
    kind_d = KIND_LINEAR;
    lo_d = '0;
    hi_d = 32'd64;
    bins_d = 32'd64;
    base_d = 32'd512;
    case (flavor)
      0: begin
        // narrow linear range
        lo_d = $urandom_range(0, 400) - 200;
        hi_d = lo_d + $urandom_range(1, 300);
        bins_d = $urandom_range(1, NUM_BINS);
      end
      1: begin
        // widest linear range
        lo_d = 32'h8000_0000;
        hi_d = 32'h7FFF_FFFF;
        bins_d = $urandom_range(0, 1) ? NUM_BINS : 1;
      end
      2: begin
        kind_d = KIND_LOG;
        lo_d = $urandom_range(1, 64);
        hi_d = $urandom;
        bins_d = $urandom_range(1, NUM_BINS);
        base_d = $urandom_range(257, 600);
      end
      3: begin
        // extreme log ratios
        kind_d = KIND_LOG;
        lo_d = $urandom_range(1, 1 << 20);
        bins_d = NUM_BINS;
        base_d = $urandom_range(0, 1) ? 32'd257 : 32'd65535;
      end
      default: begin
        // anything the write port can carry
        kind_d = $urandom;
        lo_d = $urandom;
        hi_d = $urandom;
        bins_d = $urandom;
        base_d = $urandom;
      end
    endcase
    wait_until_drained();
    write_reg(CFG_BIN_KIND, kind_d);
    write_reg(CFG_RANGE_LOW, lo_d);
    write_reg(CFG_RANGE_HIGH, hi_d);
    write_reg(CFG_BINS, bins_d);
    write_reg(CFG_LOG_BASE, base_d);
  endtask

  // Random items, mostly samples aimed at the configured bins
  task automatic run_random(int n);
    logic [1:0] mode;
    longint v, lo, hi, span;
    longint unsigned rnd;
    logic [15:0] cnt;
    logic [6:0] sel;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 72) mode = MODE_ADD;
      else if (p < 94) mode = MODE_READ;
      else if (p < 98) mode = MODE_CLEAR;
      else mode = MODE_UNUSED;
      lo = low_q;
      hi = high_q;
      span = hi - lo;
      case ($urandom_range(0, 9))
        0: v = longint'($signed($urandom));
        1: begin
          case ($urandom_range(0, 7))
            0: v = SAMPLE_MIN;
            1: v = SAMPLE_MAX;
            2: v = 0;
            3: v = -1;
            4: v = lo;
            5: v = lo - 1;
            6: v = hi;
            default: v = hi - 1;
          endcase
        end
        default: begin
          if (kind_q == KIND_LINEAR && span > 0) begin
            rnd = {$urandom, $urandom};
            v = lo - span / 16 + longint'(rnd % (span + span / 8 + 1));
          end else begin
            v = lo + longint'($urandom >> $urandom_range(0, 31));
          end
        end
      endcase
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      case ($urandom_range(0, 9))
        0: cnt = '0;
        1: cnt = '1;
        2, 3, 4, 5: cnt = $urandom_range(1, 16);
        default: cnt = $urandom_range(0, 65535);
      endcase
      sel = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_BINS + 2, 127)
                                        : $urandom_range(0, NUM_BINS + 1);
      send_item(mode, v[31:0], cnt, sel, 1'b0, RGN_NONE, '0, '0);
    end
  endtask

  initial begin : main_seq
    stim_row_t row;

    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: linear, 0 to 64, one unit per bin
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 1, 1, RGN_NONE, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 0, 1, 0, 1, RGN_INSIDE, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 63, 16'hFFFF, 0, 1, RGN_INSIDE, 63, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 64, 3, 0, 1, RGN_ABOVE, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 32'hFFFF_FFFF, 2, 0, 1, RGN_BELOW, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 32'h8000_0000, 1, 0, 1, RGN_BELOW, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 32'h7FFF_FFFF, 1, 0, 1, RGN_ABOVE, 0, 0));
    // zero repeat count classifies but adds nothing
    directed_rows.push_back(stim_item(MODE_ADD, 10, 0, 0, 1, RGN_INSIDE, 10, 0));
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 64, 1, RGN_NONE, 0, 65535));
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 0, 1, RGN_NONE, 0, 3));
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 65, 1, RGN_NONE, 0, 4));
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 127, 1, RGN_NONE, 0, 0));
    directed_rows.push_back(stim_item(MODE_UNUSED, 5, 7, 3, 1, RGN_NONE, 0, 0));
    directed_rows.push_back(stim_item(MODE_CLEAR, 0, 0, 0, 1, RGN_NONE, 0, 0));
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 64, 1, RGN_NONE, 0, 0));
    // empty linear span
    directed_rows.push_back(stim_reg(CFG_RANGE_HIGH, -32'sd5));
    directed_rows.push_back(stim_item(MODE_ADD, 100, 1, 0, 1, RGN_ABOVE, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, -32'sd7, 1, 0, 1, RGN_BELOW, 0, 0));
    // bin count clamped from below and from above
    directed_rows.push_back(stim_reg(CFG_BINS, 0));
    directed_rows.push_back(stim_reg(CFG_RANGE_HIGH, 1000));
    directed_rows.push_back(stim_item(MODE_ADD, 999, 2, 0, 1, RGN_INSIDE, 0, 0));
    directed_rows.push_back(stim_reg(CFG_BINS, 127));
    directed_rows.push_back(stim_item(MODE_ADD, 999, 2, 0, 1, RGN_INSIDE, 63, 0));
    // log bins doubling from 16
    directed_rows.push_back(stim_reg(CFG_BIN_KIND, KIND_LOG));
    directed_rows.push_back(stim_reg(CFG_RANGE_LOW, 16));
    directed_rows.push_back(stim_reg(CFG_LOG_BASE, 512));
    directed_rows.push_back(stim_reg(CFG_BINS, 4));
    directed_rows.push_back(stim_item(MODE_ADD, 16, 1, 0, 1, RGN_INSIDE, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 255, 1, 0, 1, RGN_INSIDE, 3, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 256, 1, 0, 1, RGN_ABOVE, 0, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 0, 1, 0, 1, RGN_BELOW, 0, 0));
    // log mode with a lower edge at or below zero
    directed_rows.push_back(stim_reg(CFG_RANGE_LOW, -32'sd8));
    directed_rows.push_back(stim_item(MODE_ADD, 100, 1, 0, 1, RGN_BELOW, 0, 0));
    // ratio of one stalls the edges, ratio zero shrinks them
    directed_rows.push_back(stim_reg(CFG_RANGE_LOW, 16));
    directed_rows.push_back(stim_reg(CFG_LOG_BASE, 256));
    directed_rows.push_back(stim_item(MODE_ADD, 20, 1, 0, 1, RGN_ABOVE, 0, 0));
    directed_rows.push_back(stim_reg(CFG_LOG_BASE, 0));
    directed_rows.push_back(stim_item(MODE_ADD, 16, 1, 0, 1, RGN_ABOVE, 0, 0));
    // steepest ratio runs the edges into the cap
    directed_rows.push_back(stim_reg(CFG_LOG_BASE, 65535));
    directed_rows.push_back(stim_reg(CFG_BINS, 64));
    directed_rows.push_back(stim_reg(CFG_RANGE_LOW, 1));
    directed_rows.push_back(stim_item(MODE_ADD, 32'h7FFF_FFFF, 9, 0, 0, RGN_NONE, 0, 0));
    directed_rows.push_back(stim_item(MODE_READ, 0, 0, 4, 0, RGN_NONE, 0, 0));

    send_idle_pct = 15;
    recv_stall_pct = 65;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        wait_until_drained();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.mode, row.value, row.cnt, row.sel, row.typed, row.region,
                  row.hit, row.selcnt);
      end
    end

    // Random items under three idling patterns, five settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_stall_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int s = 0; s < 5; s++) begin
        program_setting(s);
        // back up the block with a long hold-off while items keep coming
        if (phase == 2 && s == 0) hold_req = 1'b1;
        run_random(ITEMS_PER_SETTING);
      end
    end

    wait_until_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ histogram_binning_counter_core.f @@
design/hbc_pkg.sv
design/hbc_mul.sv
design/hbc_div.sv
design/hbc_bin_ram.sv
design/histogram_binning_counter_core.sv
dv/tb_histogram_binning_counter_core.sv
